### rtl/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and codes of the multi-table arithmetic range encoder.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam int unsigned CUM_W = 31;

  typedef struct packed {
    logic bit_vld;
    logic bit_val;
    logic flush;
    logic close;
  } arc_cmd_t;

endpackage

### rtl/arc_tbl_mem.sv
// ----------------------------------------------------------------------------
// arc_tbl_mem
// Cumulative-frequency table store, one write and one registered read port.
// ----------------------------------------------------------------------------
module arc_tbl_mem import arc_pkg::*; #(
  parameter int unsigned DEPTH = 4112,
  parameter int unsigned AW    = 13
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [CUM_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [CUM_W-1:0] rd_data
);

  logic [CUM_W-1:0] mem [DEPTH];
  logic [CUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/arc_div.sv
// ----------------------------------------------------------------------------
// arc_div
// Restoring divider, one quotient bit per cycle; quotient fits in QW bits.
// ----------------------------------------------------------------------------
module arc_div import arc_pkg::*; #(
  parameter int unsigned QW = 33
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [QW+CUM_W-1:0] dividend,
  input  logic [CUM_W-1:0]    divisor,
  output logic                done,
  output logic [QW-1:0]       quotient
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [CUM_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [CUM_W-1:0] div_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CUM_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[QW-1]};
    if (start) begin
      rem_nxt  = dividend[QW+CUM_W-1:QW];
      q_nxt    = dividend[QW-1:0];
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = CUM_W'(trial - {1'b0, div_r});
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CUM_W-1:0];
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### rtl/arc_pack.sv
// ----------------------------------------------------------------------------
// arc_pack
// Bit packer: gathers bits MSB first into bytes, holds the newest byte so the
// final one of a request can be marked, and drives the output register.
// ----------------------------------------------------------------------------
module arc_pack import arc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  arc_cmd_t   cmd,
  input  logic       ovf,
  output logic       ack,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic       out_tlast,
  output logic       out_tuser    // overflow
);

  logic [6:0] acc_r, acc_nxt;
  logic [2:0] fill_r, fill_nxt;
  logic       hold_vld_r, hold_vld_nxt;
  logic [7:0] hold_byte_r, hold_byte_nxt;
  logic       hold_ovf_r, hold_ovf_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_ovf_r, out_ovf_nxt;
  logic       out_free, mk;
  logic [7:0] new_byte;

  always_comb begin
    out_free      = !out_vld_r || out_tready;
    acc_nxt       = acc_r;
    fill_nxt      = fill_r;
    hold_vld_nxt  = hold_vld_r;
    hold_byte_nxt = hold_byte_r;
    hold_ovf_nxt  = hold_ovf_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    mk            = 1'b0;
    new_byte      = {acc_r, cmd.bit_val};
    if (cmd.bit_vld && fill_r == 3'd7) begin
      mk = 1'b1;
    end
    if (cmd.flush && fill_r != 3'd0) begin
      mk       = 1'b1;
      new_byte = 8'({1'b0, acc_r} << (4'd8 - {1'b0, fill_r}));
    end
    ack = 1'b1;
    if ((mk || cmd.close) && hold_vld_r && !out_free) begin
      ack = 1'b0;
    end
    if (ack) begin
      if (mk) begin
        acc_nxt  = '0;
        fill_nxt = '0;
        if (hold_vld_r) begin
          out_vld_nxt  = 1'b1;
          out_byte_nxt = hold_byte_r;
          out_last_nxt = 1'b0;
          out_ovf_nxt  = hold_ovf_r;
        end
        hold_vld_nxt  = 1'b1;
        hold_byte_nxt = new_byte;
        hold_ovf_nxt  = ovf;
      end else if (cmd.bit_vld) begin
        acc_nxt  = {acc_r[5:0], cmd.bit_val};
        fill_nxt = fill_r + 3'd1;
      end
      if (cmd.close && hold_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_byte_nxt = hold_byte_r;
        out_last_nxt = 1'b1;
        out_ovf_nxt  = hold_ovf_r;
        hold_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      fill_r     <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      fill_r     <= fill_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    hold_byte_r <= hold_byte_nxt;
    hold_ovf_r  <= hold_ovf_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

### rtl/arith_range_encoder_multitable.sv
// ----------------------------------------------------------------------------
// arith_range_encoder_multitable
// Arithmetic encoder with pending bits over several cumulative-frequency
// tables held in one synchronous memory.
// ----------------------------------------------------------------------------
// One request at a time. An encode reads three table entries, forms two
// products and divides each by the table total in a one-bit-per-cycle
// divider, then renormalizes step by step and emits one bit per cycle,
// pending bits included. A finish adds one pending bit, emits the final
// bits, then flushes and closes the output. Output back-pressure stalls
// the bit emission.
module arith_range_encoder_multitable import arc_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 256,
  parameter int unsigned TABLE_CNT   = 16,
  parameter int unsigned PENDING_MAX = 255,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // symbol[8:0], cum_value[39:9]
  input  logic [5:0]  in_tuser,   // req_type[1:0], table_sel[5:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast,
  output logic        out_tuser,  // overflow
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  localparam int unsigned CB    = COUNT_BITS;
  localparam int unsigned QW    = CB + 1;
  localparam int unsigned PWID  = QW + CUM_W;
  localparam int unsigned ROW   = MAX_SYMBOLS + 1;
  localparam int unsigned DEPTH = TABLE_CNT * ROW;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned PCW   = $clog2(PENDING_MAX + 1);
  localparam logic [CB-1:0] HALF_V    = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB-1:0] QUARTER_V = HALF_V >> 1;
  localparam logic [CB-1:0] THREEQ_V  = HALF_V | QUARTER_V;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDTOT = 4'd1;
  localparam logic [3:0] S_RDLO  = 4'd2;
  localparam logic [3:0] S_RDHI  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_MULA  = 4'd5;
  localparam logic [3:0] S_MULB  = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_RENRM = 4'd9;
  localparam logic [3:0] S_EMITB = 4'd10;
  localparam logic [3:0] S_EMITP = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_FLUSH = 4'd13;
  localparam logic [3:0] S_CLOSE = 4'd14;

  logic [3:0]        state_r, state_nxt;
  logic [8:0]        syms_r;
  logic [SW-1:0]     eff_s;
  logic [CB-1:0]     low_r, low_nxt, high_r, high_nxt;
  logic [PCW-1:0]    pend_r, pend_nxt;
  logic              ovf_r, ovf_nxt;
  logic              fin_r, fin_nxt;
  logic              bit_r, bit_nxt;
  logic              sel_lo_r, sel_lo_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [8:0]        sym_r, sym_nxt;
  logic [CUM_W-1:0]  tot_r, tot_nxt, clo_r, clo_nxt, chi_r, chi_nxt;
  logic [QW-1:0]     span_r, span_nxt;
  logic [QW+15:0]    plo_r, plo_nxt;
  logic [QW+14:0]    phi_p;
  logic [PWID-1:0]   prod_r, prod_nxt;
  logic [QW-1:0]     qhi_r, qhi_nxt;
  logic [CUM_W-1:0]  msrc;
  logic [QW:0]       nh, nl;
  logic [CB-1:0]     lsub, hsub;

  logic [1:0]        req_type;
  logic [3:0]        table_sel;
  logic [8:0]        symbol;
  logic [CUM_W-1:0]  cum_value;
  logic              acc;
  logic [AW-1:0]     in_base;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CUM_W-1:0]  mem_rdata;
  logic              div_start, div_done;
  logic [QW-1:0]     div_q;
  arc_cmd_t          cmd;
  logic              pk_ack;

  assign symbol    = in_tdata[8:0];
  assign cum_value = in_tdata[39:9];
  assign req_type  = in_tuser[1:0];
  assign table_sel = in_tuser[5:2];
  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign in_base   = AW'(table_sel) * AW'(ROW);

  always_comb begin
    if (syms_r == 9'd0) begin
      eff_s = SW'(1);
    end else if (32'(syms_r) > MAX_SYMBOLS) begin
      eff_s = SW'(MAX_SYMBOLS);
    end else begin
      eff_s = SW'(syms_r);
    end
  end

  assign mem_we    = acc && req_type == REQ_LOAD && 32'(table_sel) < TABLE_CNT
                     && 32'(symbol) <= MAX_SYMBOLS;
  assign mem_waddr = in_base + AW'(symbol);

  always_comb begin
    state_nxt  = state_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    pend_nxt   = pend_r;
    ovf_nxt    = ovf_r;
    fin_nxt    = fin_r;
    bit_nxt    = bit_r;
    sel_lo_nxt = sel_lo_r;
    base_nxt   = base_r;
    sym_nxt    = sym_r;
    tot_nxt    = tot_r;
    clo_nxt    = clo_r;
    chi_nxt    = chi_r;
    span_nxt   = span_r;
    plo_nxt    = plo_r;
    prod_nxt   = prod_r;
    qhi_nxt    = qhi_r;
    mem_re     = 1'b0;
    mem_raddr  = base_r + AW'(eff_s);
    div_start  = 1'b0;
    cmd        = '0;
    msrc       = sel_lo_r ? clo_r : chi_r;
    phi_p      = span_r * msrc[CUM_W-1:16];
    nh         = {1'b0, {1'b0, low_r}} + {1'b0, qhi_r};
    nl         = {1'b0, {1'b0, low_r}} + {1'b0, div_q};
    lsub       = low_r;
    hsub       = high_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          base_nxt = in_base;
          sym_nxt  = symbol;
          if (req_type == REQ_ENCODE) begin
            if (32'(table_sel) < TABLE_CNT && 32'(symbol) < 32'(eff_s)) begin
              fin_nxt   = 1'b0;
              state_nxt = S_RDTOT;
            end
          end else if (req_type == REQ_FINISH) begin
            fin_nxt   = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end
      S_RDTOT: begin
        mem_re    = 1'b1;
        state_nxt = S_RDLO;
      end
      S_RDLO: begin
        mem_re    = 1'b1;
        mem_raddr = base_r + AW'(sym_r);
        tot_nxt   = mem_rdata;
        state_nxt = S_RDHI;
      end
      S_RDHI: begin
        mem_re    = 1'b1;
        mem_raddr = base_r + AW'(sym_r) + AW'(1);
        clo_nxt   = mem_rdata;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        chi_nxt    = mem_rdata;
        span_nxt   = {1'b0, high_r} - {1'b0, low_r} + QW'(1);
        sel_lo_nxt = 1'b0;
        if (tot_r == '0 || clo_r >= mem_rdata || mem_rdata > tot_r) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MULA;
        end
      end
      S_MULA: begin
        plo_nxt   = span_r * msrc[15:0];
        state_nxt = S_MULB;
      end
      S_MULB: begin
        prod_nxt  = PWID'(plo_r) + (PWID'(phi_p) << 16);
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          if (!sel_lo_r) begin
            qhi_nxt    = div_q;
            sel_lo_nxt = 1'b1;
            state_nxt  = S_MULA;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        if (nh <= nl) begin
          state_nxt = S_IDLE;
        end else begin
          low_nxt   = nl[CB-1:0];
          high_nxt  = CB'(nh - (QW+1)'(1));
          state_nxt = S_RENRM;
        end
      end
      S_RENRM: begin
        if (high_r < HALF_V) begin
          bit_nxt   = 1'b0;
          state_nxt = S_EMITB;
        end else if (low_r >= HALF_V) begin
          bit_nxt   = 1'b1;
          lsub      = low_r - HALF_V;
          hsub      = high_r - HALF_V;
          state_nxt = S_EMITB;
        end else if (low_r >= QUARTER_V && high_r < THREEQ_V) begin
          if (32'(pend_r) < PENDING_MAX) begin
            pend_nxt = pend_r + PCW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          lsub = low_r - QUARTER_V;
          hsub = high_r - QUARTER_V;
        end else begin
          state_nxt = S_CLOSE;
        end
        if (state_nxt != S_CLOSE) begin
          low_nxt  = {lsub[CB-2:0], 1'b0};
          high_nxt = {hsub[CB-2:0], 1'b1};
        end
      end
      S_FIN: begin
        if (32'(pend_r) < PENDING_MAX) begin
          pend_nxt = pend_r + PCW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        bit_nxt   = (low_r >= QUARTER_V);
        state_nxt = S_EMITB;
      end
      S_EMITB: begin
        cmd.bit_vld = 1'b1;
        cmd.bit_val = bit_r;
        if (pk_ack) begin
          if (pend_r == '0) begin
            state_nxt = fin_r ? S_FLUSH : S_RENRM;
          end else begin
            state_nxt = S_EMITP;
          end
        end
      end
      S_EMITP: begin
        cmd.bit_vld = 1'b1;
        cmd.bit_val = !bit_r;
        if (pk_ack) begin
          pend_nxt = pend_r - PCW'(1);
          if (pend_r == PCW'(1)) begin
            state_nxt = fin_r ? S_FLUSH : S_RENRM;
          end
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (pk_ack) begin
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        cmd.close = 1'b1;
        if (pk_ack) begin
          if (fin_r) begin
            low_nxt  = '0;
            high_nxt = '1;
            pend_nxt = '0;
            ovf_nxt  = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      syms_r  <= 9'd256;
      low_r   <= '0;
      high_r  <= '1;
      pend_r  <= '0;
      ovf_r   <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        syms_r <= cfg_wdata;
      end
      low_r  <= low_nxt;
      high_r <= high_nxt;
      pend_r <= pend_nxt;
      ovf_r  <= ovf_nxt;
      fin_r  <= fin_nxt;
    end
    bit_r    <= bit_nxt;
    sel_lo_r <= sel_lo_nxt;
    base_r   <= base_nxt;
    sym_r    <= sym_nxt;
    tot_r    <= tot_nxt;
    clo_r    <= clo_nxt;
    chi_r    <= chi_nxt;
    span_r   <= span_nxt;
    plo_r    <= plo_nxt;
    prod_r   <= prod_nxt;
    qhi_r    <= qhi_nxt;
  end

  arc_tbl_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (cum_value),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  arc_div #(
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_nxt),
    .divisor  (tot_r),
    .done     (div_done),
    .quotient (div_q)
  );

  arc_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .ovf        (ovf_r),
    .ack        (pk_ack),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
